// ----- src/lbtd_pkg.sv -----
package lbtd_pkg;

  // table sizes
  localparam int NODE_COUNT      = 8;
  localparam int TASK_COUNT      = 16;
  localparam int FIRST_USER_TASK = 4;

  localparam int NODE_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int TASK_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int NCNT_W = NODE_W + 1;
  localparam int TCNT_W = TASK_W + 1;

  // fixed field widths
  localparam int OP_W         = 2;
  localparam int TIME_W       = 32;
  localparam int LOAD_W       = 8;
  localparam int NODE_NUM_W   = 8;
  localparam int CMD_TASK_W   = 8;
  localparam int HOME_W       = 4;
  localparam int ENTRY_TASK_W = 4;
  localparam int SANE_MAP_W   = 8;
  localparam int WINDOW_W     = 16;
  localparam int SPREAD_W     = 8;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;

  localparam logic [WINDOW_W-1:0] WINDOW_RST = WINDOW_W'(750);
  localparam logic [SPREAD_W-1:0] SPREAD_RST = SPREAD_W'(2);

  localparam logic [HOME_W-1:0] HOME_NONE = {HOME_W{1'b1}};

  // least-load search starts above any useful load
  localparam logic [LOAD_W-1:0] MIN_LOAD_START = LOAD_W'(TASK_COUNT + 1);

  localparam logic [CMD_TASK_W-1:0] CMD_TASK_LO = CMD_TASK_W'(FIRST_USER_TASK);
  localparam logic [CMD_TASK_W-1:0] CMD_TASK_HI = CMD_TASK_W'(TASK_COUNT);

  localparam int TASK_START_I = (FIRST_USER_TASK < TASK_COUNT) ? FIRST_USER_TASK : TASK_COUNT;
  localparam logic [TCNT_W-1:0] TASK_START = TCNT_W'(TASK_START_I);
  localparam logic [TCNT_W-1:0] TASK_END   = TCNT_W'(TASK_COUNT);
  localparam logic [TCNT_W-1:0] TASK_LAST  = TCNT_W'(TASK_COUNT - 1);
  localparam logic [NCNT_W-1:0] NODE_END   = NCNT_W'(NODE_COUNT);
  localparam logic [NODE_W-1:0] NODE_LAST  = NODE_W'(NODE_COUNT - 1);

  typedef enum logic [OP_W-1:0] {
    OP_REPORT = 2'd0,
    OP_ASSIGN = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STALE_WINDOW   = 1'b0,
    CFG_MIGRATE_SPREAD = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    KIND_ACK   = 1'b0,
    KIND_ENTRY = 1'b1
  } result_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK,
    ST_NODE,
    ST_PLACE,
    ST_MIGRATE,
    ST_EMIT_RD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [LOAD_W-1:0] load;
    logic [TIME_W-1:0] stamp;
  } node_word_t;

  localparam int NODE_WORD_W = $bits(node_word_t);

  // node number modulo NODE_COUNT by restoring subtraction of shifted counts
  function automatic logic [NODE_W-1:0] node_reduce(input logic [NODE_NUM_W-1:0] v);
    logic [15:0] r;
    r = {8'b0, v};
    for (int k = 7; k >= 0; k--) begin
      if (r >= 16'(NODE_COUNT << k)) begin
        r = r - 16'(NODE_COUNT << k);
      end
    end
    return r[NODE_W-1:0];
  endfunction

  function automatic logic home_is_node(input logic [HOME_W-1:0] h);
    return !h[HOME_W-1] && (int'(h[HOME_W-2:0]) < NODE_COUNT);
  endfunction

  function automatic logic [NODE_W-1:0] home_idx(input logic [HOME_W-1:0] h);
    return NODE_W'(h[HOME_W-2:0]);
  endfunction

  function automatic logic [HOME_W-1:0] home_of(input logic found,
                                               input logic [NODE_W-1:0] idx);
    return found ? HOME_W'(idx) : HOME_NONE;
  endfunction

endpackage

// ----- src/lbtd_ram.sv -----
module lbtd_ram #(
  parameter int              DEPTH   = 8,
  parameter int              WIDTH   = 8,
  parameter logic [WIDTH-1:0] RST_VAL = '0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  // entries never written read as the reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : RST_VAL;

endmodule

// ----- src/load_balancing_task_distributor.sv -----
// load balancing task distributor
//
// input channel (in_valid_i / in_ready_o) takes one word per item:
//   node report  - stores load, sane mark and time stamp of one node, no result
//   assignment   - sets the home node of a user task, one acknowledge word through
//                  the ack state and the output register after acceptance
//   period tick  - clears stale sane marks (one node memory read per cycle), places
//                  homeless user tasks or migrates one task (one task memory
//                  read-modify-write per cycle), then streams the whole task table,
//                  one word per cycle while the receiver takes them
// the block takes a new item once back in idle, also while its last word still waits
// output channel (out_valid_o / out_ready_i) is a single output register; a stalled
// receiver holds the table stream, the payload stays put until the word is taken
// reset: all nodes insane with zero load and time, every task unassigned, stale
// window 750, migrate spread 2; memories use per-entry valid bits, no clearing pass
// config writes (cfg_we_i) take effect at once and are meant for idle periods
module load_balancing_task_distributor
  import lbtd_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [OP_W-1:0]              operation_i,
  input  logic [TIME_W-1:0]            now_ms_i,
  input  logic [NODE_NUM_W-1:0]        reporting_node_i,
  input  logic                         report_sane_i,
  input  logic [LOAD_W-1:0]            report_load_i,
  input  logic [CMD_TASK_W-1:0]        command_task_i,
  input  logic signed [HOME_W-1:0]     command_node_i,

  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         result_kind_o,
  output logic                         command_accepted_o,
  output logic [ENTRY_TASK_W-1:0]      entry_task_o,
  output logic signed [HOME_W-1:0]     entry_node_o,
  output logic [SANE_MAP_W-1:0]        sane_map_o,
  output logic                         last_entry_o,

  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i
);

  state_e state_q, state_d;

  // configuration
  logic [WINDOW_W-1:0] window_q;
  logic [SPREAD_W-1:0] spread_q;

  // sane marks live in flops, the whole map goes out with every word
  logic [NODE_COUNT-1:0] sane_q;

  // node scan
  logic [NCNT_W-1:0] ncnt_q;
  logic              nvld_q;
  logic [NODE_W-1:0] nidx_q;
  logic              dl_ok_q;
  logic [TIME_W-1:0] dl_q;
  logic [LOAD_W-1:0] min_load_q, max_load_q;
  logic [NODE_W-1:0] min_idx_q, max_idx_q;
  logic              min_fnd_q, max_fnd_q;

  // task scan and table stream
  logic [TCNT_W-1:0] tcnt_q;
  logic              tvld_q;
  logic [TASK_W-1:0] tidx_q;
  logic              placed_q;
  logic              mig_fnd_q;
  logic [TASK_W-1:0] mig_idx_q;

  // pending acknowledge
  logic                    ack_ok_q;
  logic [ENTRY_TASK_W-1:0] ack_task_q;
  logic [HOME_W-1:0]       ack_node_q;

  // output register
  logic                    ovld_q;
  logic                    okind_q;
  logic                    oacc_q;
  logic [ENTRY_TASK_W-1:0] otask_q;
  logic [HOME_W-1:0]       onode_q;
  logic [SANE_MAP_W-1:0]   osane_q;
  logic                    olast_q;

  // memory ports
  logic              n_we;
  logic [NODE_W-1:0] n_waddr, n_raddr;
  node_word_t        n_wdata, n_rdata;
  logic              t_we;
  logic [TASK_W-1:0] t_waddr, t_raddr;
  logic [HOME_W-1:0] t_wdata, t_rdata;

  // strobes
  logic in_fire;
  logic out_free;
  logic node_issue;
  logic task_issue;
  logic out_load;
  logic emit_take;

  // item decode
  logic              assign_ok;
  logic [HOME_W-1:0] assign_home;
  logic [NODE_W-1:0] rep_node;

  // per-step evaluation
  logic              node_stale;
  logic              node_ok;
  logic              homeless;
  logic              migrate_go;
  logic [LOAD_W:0]   spread_now;

  lbtd_ram #(
    .DEPTH   (NODE_COUNT),
    .WIDTH   (NODE_WORD_W),
    .RST_VAL ('0)
  ) u_node_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .raddr_i (n_raddr),
    .rdata_o (n_rdata)
  );

  lbtd_ram #(
    .DEPTH   (TASK_COUNT),
    .WIDTH   (HOME_W),
    .RST_VAL (HOME_NONE)
  ) u_task_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !ovld_q || out_ready_i;

  assign rep_node    = node_reduce(reporting_node_i);
  assign assign_ok   = (command_task_i >= CMD_TASK_LO) && (command_task_i < CMD_TASK_HI);
  assign assign_home = home_is_node(command_node_i) ? command_node_i : HOME_NONE;

  // staleness without wrap: no node goes stale while now is below the window
  assign node_stale = dl_ok_q && (n_rdata.stamp < dl_q);
  assign node_ok    = sane_q[nidx_q] && !node_stale;

  assign homeless = !home_is_node(t_rdata) || !sane_q[home_idx(t_rdata)];

  assign spread_now = {1'b0, max_load_q} - {1'b0, min_load_q};
  assign migrate_go = !placed_q && min_fnd_q && max_fnd_q && mig_fnd_q &&
                      (spread_now >= {1'b0, spread_q});

  // sequencer: next state and memory port control
  always_comb begin
    state_d    = state_q;
    n_we       = 1'b0;
    n_waddr    = rep_node;
    n_wdata    = '{load: report_load_i, stamp: now_ms_i};
    n_raddr    = ncnt_q[NODE_W-1:0];
    t_we       = 1'b0;
    t_waddr    = tidx_q;
    t_wdata    = home_of(min_fnd_q, min_idx_q);
    t_raddr    = tcnt_q[TASK_W-1:0];
    node_issue = 1'b0;
    task_issue = 1'b0;
    out_load   = 1'b0;
    emit_take  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (operation_i)
            OP_REPORT: begin
              n_we = 1'b1;
            end
            OP_ASSIGN: begin
              t_we    = assign_ok;
              t_waddr = command_task_i[TASK_W-1:0];
              t_wdata = assign_home;
              state_d = ST_ACK;
            end
            OP_TICK: begin
              state_d = ST_NODE;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ACK: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_NODE: begin
        // one node read issued per cycle, evaluated in the cycle after
        node_issue = (ncnt_q < NODE_END);
        if (nvld_q && (nidx_q == NODE_LAST)) begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        // read task t while writing back task t-1
        task_issue = (tcnt_q < TASK_END);
        t_we       = tvld_q && homeless;
        if ((tvld_q && ({1'b0, tidx_q} == TASK_LAST)) || (!tvld_q && !task_issue)) begin
          state_d = ST_MIGRATE;
        end
      end
      ST_MIGRATE: begin
        t_we    = migrate_go;
        t_waddr = mig_idx_q;
        state_d = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // keep the read address one ahead whenever a word leaves
        if (out_free) begin
          out_load  = 1'b1;
          emit_take = 1'b1;
          t_raddr   = TASK_W'(tcnt_q + 1'b1);
          if (tcnt_q == TASK_LAST) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RST;
      spread_q <= SPREAD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STALE_WINDOW:   window_q <= cfg_data_i[WINDOW_W-1:0];
        CFG_MIGRATE_SPREAD: spread_q <= cfg_data_i[SPREAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // control state of the scans
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sane_q    <= '0;
      ncnt_q    <= '0;
      nvld_q    <= 1'b0;
      min_fnd_q <= 1'b0;
      max_fnd_q <= 1'b0;
      tcnt_q    <= '0;
      tvld_q    <= 1'b0;
      placed_q  <= 1'b0;
      mig_fnd_q <= 1'b0;
      ovld_q    <= 1'b0;
    end else begin
      nvld_q <= node_issue;
      tvld_q <= task_issue;

      if (n_we) begin
        sane_q[rep_node] <= report_sane_i;
      end

      if (in_fire && (operation_i == OP_TICK)) begin
        ncnt_q    <= '0;
        min_fnd_q <= 1'b0;
        max_fnd_q <= 1'b0;
      end

      if (node_issue) begin
        ncnt_q <= ncnt_q + 1'b1;
      end

      // first least-loaded and first most-loaded sane node
      if (nvld_q) begin
        if (node_stale) begin
          sane_q[nidx_q] <= 1'b0;
        end
        if (node_ok && (n_rdata.load < min_load_q)) begin
          min_fnd_q <= 1'b1;
        end
        if (node_ok && (n_rdata.load > max_load_q)) begin
          max_fnd_q <= 1'b1;
        end
      end

      if ((state_q == ST_NODE) && (state_d == ST_PLACE)) begin
        tcnt_q    <= TASK_START;
        placed_q  <= 1'b0;
        mig_fnd_q <= 1'b0;
      end

      if (task_issue) begin
        tcnt_q <= tcnt_q + 1'b1;
      end

      if (tvld_q) begin
        if (homeless) begin
          placed_q <= 1'b1;
        end
        // first task on the busiest node is the migration candidate
        if (!mig_fnd_q && max_fnd_q && (t_rdata == home_of(1'b1, max_idx_q))) begin
          mig_fnd_q <= 1'b1;
        end
      end

      if (state_q == ST_MIGRATE) begin
        tcnt_q <= '0;
      end

      if (emit_take) begin
        tcnt_q <= tcnt_q + 1'b1;
      end

      if (out_load) begin
        ovld_q <= 1'b1;
      end else if (out_ready_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire && (operation_i == OP_TICK)) begin
      dl_ok_q    <= (now_ms_i >= TIME_W'(window_q));
      dl_q       <= now_ms_i - TIME_W'(window_q);
      min_load_q <= MIN_LOAD_START;
      max_load_q <= '0;
    end

    if (node_issue) begin
      nidx_q <= ncnt_q[NODE_W-1:0];
    end

    if (nvld_q) begin
      if (node_ok && (n_rdata.load < min_load_q)) begin
        min_load_q <= n_rdata.load;
        min_idx_q  <= nidx_q;
      end
      if (node_ok && (n_rdata.load > max_load_q)) begin
        max_load_q <= n_rdata.load;
        max_idx_q  <= nidx_q;
      end
    end

    if (task_issue) begin
      tidx_q <= tcnt_q[TASK_W-1:0];
    end

    if (tvld_q && !mig_fnd_q && max_fnd_q && (t_rdata == home_of(1'b1, max_idx_q))) begin
      mig_idx_q <= tidx_q;
    end

    if (in_fire && (operation_i == OP_ASSIGN)) begin
      ack_ok_q   <= assign_ok;
      ack_task_q <= command_task_i[ENTRY_TASK_W-1:0];
      ack_node_q <= assign_home;
    end

    if (out_load) begin
      osane_q <= SANE_MAP_W'(sane_q);
      if (state_q == ST_ACK) begin
        okind_q <= KIND_ACK;
        oacc_q  <= ack_ok_q;
        otask_q <= ack_task_q;
        onode_q <= ack_node_q;
        olast_q <= 1'b1;
      end else begin
        okind_q <= KIND_ENTRY;
        oacc_q  <= 1'b0;
        otask_q <= ENTRY_TASK_W'(tcnt_q);
        onode_q <= t_rdata;
        olast_q <= (tcnt_q == TASK_LAST);
      end
    end
  end

  assign out_valid_o        = ovld_q;
  assign result_kind_o      = okind_q;
  assign command_accepted_o = oacc_q;
  assign entry_task_o       = otask_q;
  assign entry_node_o       = onode_q;
  assign sane_map_o         = osane_q;
  assign last_entry_o       = olast_q;

endmodule
